FILE: hdl/wpan_pkg.sv
package wpan_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int IDX_BITS    = COUNT_BITS + 1;
    localparam int DIV_STEPS   = SAMPLE_BITS - 1;
    localparam int STEP_BITS   = $clog2(DIV_STEPS + 1);

    localparam logic [ADDR_BITS-1:0]  TARGET_RESET = ADDR_BITS'(5986 / 4);
    localparam logic [COUNT_BITS-1:0] COUNT_FULL   = COUNT_BITS'(MAX_SAMPLES);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_RD   = 5'b00100,
        S_LAT  = 5'b01000,
        S_DIV  = 5'b10000
    } state_t;

endpackage

FILE: hdl/waveform_peak_align_normalize.sv
// Peak-aligned, peak-normalized waveform store.
// Request channel: start/busy. A request is taken at a clock edge with start high
// and busy low. cmd = load writes sample into the store at once (first restarts
// the waveform); busy stays low, so loads may arrive every cycle and give no result.
// cmd = read returns one bin of the waveform rotated so its peak lands at
// target_bin, divided by the peak in saturated Q1.15.
// A read holds busy through index reduction modulo the loaded count (a
// compare and subtract per cycle), a store read, a setup step and the
// restoring divider that yields one quotient bit per cycle. A sample whose
// magnitude reaches the peak saturates at the setup step, so that read skips
// the divider.
// Range or peak errors give the result in the next cycle without raising busy.
// The result shows on value, peak_index, peak_bad and range_error for one
// cycle with done high; the next request is taken in that same cycle. The
// receiver cannot stall, so results are never held.
// The user must write target_bin via cfg_we/cfg_wdata only while idle; not enforced.
// Reset clears count and the state machine, sets peak to its minimum and
// target_bin to 1496; the store is not cleared, only entries below count are read.
module waveform_peak_align_normalize (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic signed [wpan_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                 first,
    input  logic [wpan_pkg::ADDR_BITS-1:0]       position,
    input  logic                                 cfg_we,
    input  logic [wpan_pkg::ADDR_BITS-1:0]       cfg_wdata,
    output logic                                 done,
    output logic signed [wpan_pkg::SAMPLE_BITS-1:0] value,
    output logic [wpan_pkg::ADDR_BITS-1:0]       peak_index,
    output logic                                 peak_bad,
    output logic                                 range_error
);

    localparam int SB = wpan_pkg::SAMPLE_BITS;
    localparam int AB = wpan_pkg::ADDR_BITS;
    localparam int CB = wpan_pkg::COUNT_BITS;
    localparam int IB = wpan_pkg::IDX_BITS;
    localparam int TB = wpan_pkg::STEP_BITS;

    logic signed [SB-1:0] mem [wpan_pkg::MAX_SAMPLES];
    logic signed [SB-1:0] rd_data_reg;

    wpan_pkg::state_t state_reg, state_next;
    logic [AB-1:0]        target_reg, target_next;
    logic [CB-1:0]        count_reg, count_next;
    logic signed [SB-1:0] peak_reg, peak_next;
    logic [AB-1:0]        ppos_reg, ppos_next;
    logic [IB-1:0]        idx_reg, idx_next;
    logic [SB-2:0]        rem_reg, rem_next;
    logic [SB-2:0]        quo_reg, quo_next;
    logic                 neg_reg, neg_next;
    logic [TB-1:0]        step_reg, step_next;
    logic                 done_reg, done_next;
    logic signed [SB-1:0] value_reg, value_next;
    logic [AB-1:0]        pidx_reg, pidx_next;
    logic                 bad_reg, bad_next;
    logic                 rerr_reg, rerr_next;

    logic                 accept;
    logic [CB-1:0]        eff_count;
    logic signed [SB-1:0] eff_peak;
    logic                 wr_en;
    logic                 rerr_now;
    logic                 bad_now;
    logic [IB-1:0]        idx_sum;
    logic [SB:0]          abs_s;
    logic                 ovf;
    logic [SB-1:0]        rem2;
    logic                 ge;
    logic [SB-1:0]        divisor;

    assign accept   = start && (state_reg == wpan_pkg::S_IDLE);
    assign busy     = (state_reg != wpan_pkg::S_IDLE);
    assign eff_count = first ? '0 : count_reg;
    assign eff_peak  = first ? {1'b1, {(SB-1){1'b0}}} : peak_reg;
    assign wr_en    = accept && (cmd == wpan_pkg::CMD_LOAD)
                      && (eff_count < wpan_pkg::COUNT_FULL);

    assign rerr_now = ({1'b0, position} >= count_reg) || ({1'b0, target_reg} >= count_reg);
    assign bad_now  = (peak_reg <= 0);
    assign idx_sum  = IB'(position) + IB'(ppos_reg) + IB'(count_reg) - IB'(target_reg);

    assign divisor  = {1'b0, peak_reg[SB-2:0]};
    assign abs_s    = rd_data_reg[SB-1] ? (SB+1)'(-{rd_data_reg[SB-1], rd_data_reg})
                                        : {1'b0, rd_data_reg};
    assign ovf      = (abs_s >= {1'b0, divisor});
    assign rem2     = {rem_reg, 1'b0};
    assign ge       = (rem2 >= divisor);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[eff_count[AB-1:0]] <= sample;
        end
        rd_data_reg <= mem[idx_reg[AB-1:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        target_next = cfg_we ? cfg_wdata : target_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        ppos_next   = ppos_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        pidx_next   = pidx_reg;
        bad_next    = bad_reg;
        rerr_next   = rerr_reg;
        unique case (state_reg)
            wpan_pkg::S_IDLE:
            begin
                if (accept && (cmd == wpan_pkg::CMD_LOAD))
                begin
                    count_next = eff_count;
                    peak_next  = eff_peak;
                    if (first)
                    begin
                        ppos_next = '0;
                    end
                    if (wr_en)
                    begin
                        if ((eff_count == '0) || (sample > eff_peak))
                        begin
                            peak_next = sample;
                            ppos_next = eff_count[AB-1:0];
                        end
                        count_next = eff_count + CB'(1);
                    end
                end
                else if (accept)
                begin
                    pidx_next = ppos_reg;
                    bad_next  = bad_now;
                    rerr_next = rerr_now;
                    idx_next  = idx_sum;
                    if (rerr_now || bad_now)
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = wpan_pkg::S_MOD;
                    end
                end
            end
            wpan_pkg::S_MOD:
            begin
                if (idx_reg >= IB'(count_reg))
                begin
                    idx_next = idx_reg - IB'(count_reg);
                end
                else
                begin
                    state_next = wpan_pkg::S_RD;
                end
            end
            wpan_pkg::S_RD:
            begin
                state_next = wpan_pkg::S_LAT;
            end
            wpan_pkg::S_LAT:
            begin
                neg_next  = rd_data_reg[SB-1];
                rem_next  = abs_s[SB-2:0];
                quo_next  = '0;
                step_next = '0;
                if (ovf)
                begin
                    value_next = rd_data_reg[SB-1] ? {1'b1, {(SB-1){1'b0}}}
                                                   : {1'b0, {(SB-1){1'b1}}};
                    done_next  = 1'b1;
                    state_next = wpan_pkg::S_IDLE;
                end
                else
                begin
                    state_next = wpan_pkg::S_DIV;
                end
            end
            wpan_pkg::S_DIV:
            begin
                rem_next  = ge ? (SB-1)'(rem2 - divisor) : rem2[SB-2:0];
                quo_next  = {quo_reg[SB-3:0], ge};
                step_next = step_reg + TB'(1);
                if (step_reg == TB'(wpan_pkg::DIV_STEPS - 1))
                begin
                    value_next = neg_reg ? SB'(-{1'b0, quo_reg[SB-3:0], ge})
                                         : {1'b0, quo_reg[SB-3:0], ge};
                    done_next  = 1'b1;
                    state_next = wpan_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wpan_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wpan_pkg::S_IDLE;
            target_reg <= wpan_pkg::TARGET_RESET;
            count_reg  <= '0;
            peak_reg   <= {1'b1, {(SB-1){1'b0}}};
            ppos_reg   <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            peak_reg   <= peak_next;
            ppos_reg   <= ppos_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
        pidx_reg  <= pidx_next;
        bad_reg   <= bad_next;
        rerr_reg  <= rerr_next;
    end

    assign done        = done_reg;
    assign value       = value_reg;
    assign peak_index  = pidx_reg;
    assign peak_bad    = bad_reg;
    assign range_error = rerr_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == wpan_pkg::S_IDLE))
        else $error("result strobe outside idle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (bad_reg || rerr_reg)) |-> (value_reg == '0))
        else $error("nonzero value with error flag");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wpan_pkg::S_DIV) |-> (step_reg < TB'(wpan_pkg::DIV_STEPS)))
        else $error("divider step overrun");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= wpan_pkg::COUNT_FULL)
        else $error("sample count beyond store depth");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == wpan_pkg::CMD_READ) && !rerr_now && !bad_now) |=> busy)
        else $error("valid read did not raise busy");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == wpan_pkg::CMD_LOAD)) |=> (!done_reg && !busy))
        else $error("load produced a result or busy");

endmodule
